// ----- rtl/slc_pkg.sv -----
`timescale 1ns / 1ps
package slc_pkg;

	localparam int DEF_CHANNELS = 1024;
	localparam int FIFO_DEPTH   = 2;
	localparam int CH_W         = 10;
	localparam int GATE_W       = 24;
	localparam int HID_W        = 18;
	localparam int ST_W         = 40;

	localparam int DIV_NW = 56;
	localparam int DIV_DW = 48;
	localparam int DIV_QW = 41;

	localparam logic signed [GATE_W-1:0] IGATE_HI = 24'sd655360;
	localparam logic signed [GATE_W-1:0] IGATE_LO = -24'sd655360;
	localparam logic signed [25:0] EXP_HI = 26'sd5767168;
	localparam logic signed [25:0] EXP_LO = -26'sd5701632;
	localparam logic signed [17:0] LOG2E_HI = 18'sd47274;
	localparam logic signed [17:0] LOG2E_LO = 18'sd7573;
	localparam logic signed [18:0] POLY_C1 = 19'sd45426;
	localparam logic signed [18:0] POLY_C2 = 19'sd15743;
	localparam logic signed [18:0] POLY_C3 = 19'sd3657;
	localparam logic signed [18:0] ONE_Q16 = 19'sd65536;
	localparam logic [47:0] EXP_SAT = 48'h8000_0000_0000;
	localparam logic signed [ST_W-1:0] STATE_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [ST_W-1:0] STATE_MIN = 40'sh80_0000_0000;

	typedef struct packed {
		logic [CH_W-1:0]          channel;
		logic                     ch_ok;
		logic signed [GATE_W-1:0] ig;
		logic signed [GATE_W-1:0] fg_raw;
		logic signed [GATE_W-1:0] z_raw;
		logic signed [GATE_W-1:0] o_raw;
		logic                     last;
	} slc_item_t;

	typedef struct packed {
		logic signed [HID_W-1:0] hidden;
		logic [CH_W-1:0]         channel;
		logic                    last;
	} slc_res_t;

endpackage

// ----- rtl/slc_fifo.sv -----
`timescale 1ns / 1ps
module slc_fifo
	import slc_pkg::*;
#(
	parameter type T = logic,
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	T mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = cnt_q == NW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end
endmodule

// ----- rtl/slc_front.sv -----
`timescale 1ns / 1ps
module slc_front
	import slc_pkg::*;
#(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [CH_W-1:0]          channel,
	input  logic signed [GATE_W-1:0] input_gate_raw,
	input  logic signed [GATE_W-1:0] forget_gate_raw,
	input  logic signed [GATE_W-1:0] cell_input_raw,
	input  logic signed [GATE_W-1:0] output_gate_raw,
	input  logic                     last_step,
	input  logic                     clearing,
	input  logic                     q_pop,
	output slc_item_t                q_head,
	output logic                     q_empty
);
	slc_item_t item;
	logic q_full;

	always_comb begin
		item.channel = channel;
		item.ch_ok   = int'(channel) < CHANNELS;
		if (input_gate_raw < IGATE_LO) begin
			item.ig = IGATE_LO;
		end else if (input_gate_raw > IGATE_HI) begin
			item.ig = IGATE_HI;
		end else begin
			item.ig = input_gate_raw;
		end
		item.fg_raw = forget_gate_raw;
		item.z_raw  = cell_input_raw;
		item.o_raw  = output_gate_raw;
		item.last   = last_step;
	end

	// hold off transactions while state memory is cleared
	assign full = q_full | clearing;

	slc_fifo #(
		.T(slc_item_t),
		.DEPTH(FIFO_DEPTH)
	) u_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push & ~full),
		.wdata(item),
		.full(q_full),
		.pop(q_pop),
		.rdata(q_head),
		.empty(q_empty)
	);
endmodule

// ----- rtl/slc_div.sv -----
`timescale 1ns / 1ps
module slc_div
	import slc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_QW-1:0] quo
);
	localparam int CNT_W = $clog2(DIV_QW + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DIV_DW-1:0] rem_q, den_q;
	logic [DIV_QW-1:0] sh_q;
	logic [DIV_DW:0]   trial, diff;
	logic              ge;

	assign trial = {rem_q, sh_q[DIV_QW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1)) && !start;
			if (start) begin
				cnt_q <= CNT_W'(DIV_QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_DW'(num >> DIV_QW);
			sh_q  <= num[DIV_QW-1:0];
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			sh_q  <= {sh_q[DIV_QW-2:0], ge};
		end
	end
endmodule

// ----- rtl/slc_back.sv -----
`timescale 1ns / 1ps
module slc_back
	import slc_pkg::*;
#(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  slc_item_t q_head,
	output logic      q_pop,
	output logic      clearing,
	output logic      res_push,
	output slc_res_t  res,
	input  logic      res_full
);
	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW = $clog2(CHANNELS + 1);
	localparam int SW = 5;

	localparam logic [SW-1:0] S_CLR  = 5'd0;
	localparam logic [SW-1:0] S_IDLE = 5'd1;
	localparam logic [SW-1:0] S_EXX  = 5'd2;
	localparam logic [SW-1:0] S_EXA  = 5'd3;
	localparam logic [SW-1:0] S_EXB  = 5'd4;
	localparam logic [SW-1:0] S_EXT  = 5'd5;
	localparam logic [SW-1:0] S_EXK  = 5'd6;
	localparam logic [SW-1:0] S_EXM  = 5'd7;
	localparam logic [SW-1:0] S_EXP  = 5'd8;
	localparam logic [SW-1:0] S_EXS  = 5'd9;
	localparam logic [SW-1:0] S_GATE = 5'd10;
	localparam logic [SW-1:0] S_DIVW = 5'd11;
	localparam logic [SW-1:0] S_U1   = 5'd12;
	localparam logic [SW-1:0] S_U2   = 5'd13;
	localparam logic [SW-1:0] S_U3   = 5'd14;
	localparam logic [SW-1:0] S_U4   = 5'd15;
	localparam logic [SW-1:0] S_U5   = 5'd16;
	localparam logic [SW-1:0] S_QW   = 5'd17;
	localparam logic [SW-1:0] S_H1   = 5'd18;
	localparam logic [SW-1:0] S_H2   = 5'd19;
	localparam logic [SW-1:0] S_OUT  = 5'd20;

	localparam logic [1:0] OP_F = 2'd0;
	localparam logic [1:0] OP_I = 2'd1;
	localparam logic [1:0] OP_Z = 2'd2;
	localparam logic [1:0] OP_O = 2'd3;

	localparam logic [1:0] PSTEP_LAST = 2'd2;
	localparam logic [DIV_QW-1:0] QSAT = 41'd8589934592;

	function automatic logic signed [63:0] rs16(input logic signed [63:0] v);
		rs16 = (v + 64'sd32768) >>> 16;
	endfunction

	function automatic logic signed [63:0] rs30(input logic signed [63:0] v);
		rs30 = (v + 64'sd536870912) >>> 30;
	endfunction

	function automatic logic signed [ST_W-1:0] sat40(input logic signed [41:0] v);
		if (v > 42'(STATE_MAX)) begin
			sat40 = STATE_MAX;
		end else if (v < 42'(STATE_MIN)) begin
			sat40 = STATE_MIN;
		end else begin
			sat40 = v[ST_W-1:0];
		end
	endfunction

	logic [SW-1:0] state_q, state_d;
	logic [1:0]    op_q, pstep_q;
	logic [CW-1:0] clr_q;

	slc_item_t item_q;
	logic signed [23:0] x_q;
	logic signed [59:0] acc_q;
	logic signed [25:0] t_q;
	logic signed [8:0]  k_q;
	logic signed [16:0] r_q;
	logic signed [18:0] p_q;
	logic [47:0]        e_q;
	logic [16:0]        fg_q, og_q;
	logic [31:0]        ii_q;
	logic signed [17:0] zz_q;
	logic signed [41:0] cf_q, nacc_q;
	logic signed [ST_W-1:0] c1_q, n1_q;
	logic signed [DIV_QW-1:0] qv_q;
	logic signed [HID_W-1:0]  h_q;
	logic signed [58:0] prod_q;
	logic [2*ST_W-1:0]  rdata_q;
	logic [2*ST_W-1:0]  mem [CHANNELS];

	logic signed [17:0] mul_a;
	logic signed [40:0] mul_b;
	logic signed [25:0] x_raw, x_cl;
	logic signed [26:0] tk;
	logic signed [18:0] pc;
	logic [16:0]        p_u;
	logic [8:0]         kn;
	logic [47:0]        e_next, d48;
	logic signed [ST_W-1:0] c0, n0, c1_next, n1_next;
	logic [ST_W-1:0]    c_mag, n_mag, den;
	logic [DIV_QW-1:0]  qs;
	logic signed [63:0] h_full;

	logic              div_start, div_done;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic [DIV_QW-1:0] div_quo;
	logic [16:0]       g;

	logic              we, rd_en;
	logic [AW-1:0]     wa, ra;
	logic [2*ST_W-1:0] wd;

	assign clearing = state_q == S_CLR;
	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign rd_en    = q_pop;
	assign ra       = AW'(q_head.channel);
	assign res_push = (state_q == S_OUT) && !res_full;
	assign res      = '{hidden: h_q, channel: item_q.channel, last: item_q.last};

	assign c0 = item_q.ch_ok ? signed'(rdata_q[2*ST_W-1:ST_W]) : '0;
	assign n0 = item_q.ch_ok ? signed'(rdata_q[ST_W-1:0]) : '0;

	always_comb begin
		unique case (op_q)
			OP_F:    x_raw = -26'(item_q.fg_raw);
			OP_I:    x_raw = 26'(item_q.ig);
			OP_Z:    x_raw = -(26'(item_q.z_raw) <<< 1);
			OP_O:    x_raw = -26'(item_q.o_raw);
			default: x_raw = '0;
		endcase
		if (x_raw < EXP_LO) begin
			x_cl = EXP_LO;
		end else if (x_raw > EXP_HI) begin
			x_cl = EXP_HI;
		end else begin
			x_cl = x_raw;
		end
	end

	assign tk = 27'(t_q) + 27'sd32768;

	always_comb begin
		case (pstep_q)
			2'd0:    pc = POLY_C2;
			2'd1:    pc = POLY_C1;
			default: pc = ONE_Q16;
		endcase
	end

	// 2^k scaling of the polynomial
	assign p_u = p_q[16:0];
	assign kn  = 9'(-k_q);
	always_comb begin
		if (!k_q[8]) begin
			if (k_q > 9'sd30) begin
				e_next = EXP_SAT;
			end else begin
				e_next = 48'(p_u) << k_q[4:0];
			end
		end else if (kn > 9'd40) begin
			e_next = '0;
		end else begin
			e_next = (48'(p_u) + (48'd1 << (kn[5:0] - 6'd1))) >> kn[5:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_EXA: begin
				mul_a = LOG2E_HI;
				mul_b = 41'(x_q);
			end
			S_EXB: begin
				mul_a = LOG2E_LO;
				mul_b = 41'(x_q);
			end
			S_EXM: begin
				mul_a = 18'(r_q);
				mul_b = 41'(p_q);
			end
			S_U1: begin
				mul_a = {1'b0, fg_q};
				mul_b = 41'(c0);
			end
			S_U2: begin
				mul_a = {1'b0, fg_q};
				mul_b = 41'(n0);
			end
			S_U3: begin
				mul_a = zz_q;
				mul_b = {9'b0, ii_q};
			end
			S_H1: begin
				mul_a = {1'b0, og_q};
				mul_b = qv_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign c1_next = sat40(cf_q + 42'(rs16(64'(prod_q))));
	assign n1_next = sat40(nacc_q);

	assign c_mag = c1_q[ST_W-1] ? ST_W'(-c1_q) : ST_W'(c1_q);
	assign n_mag = n1_q[ST_W-1] ? ST_W'(-n1_q) : ST_W'(n1_q);
	assign den   = (n_mag > 40'd65536) ? n_mag : 40'd65536;
	assign d48   = e_q + 48'd65536;

	always_comb begin
		if (state_q == S_GATE) begin
			div_num = 56'h1_0000_0000 + DIV_NW'(d48 >> 1);
			div_den = d48;
		end else begin
			div_num = (DIV_NW'(c_mag) << 16) + DIV_NW'(den >> 1);
			div_den = DIV_DW'(den);
		end
	end
	assign div_start = ((state_q == S_GATE) && (op_q != OP_I)) || (state_q == S_U5);
	assign g  = div_quo[16:0];
	assign qs = (div_quo > QSAT) ? QSAT : div_quo;

	assign h_full = rs16(64'(prod_q));

	assign we = clearing || ((state_q == S_U4) && item_q.ch_ok);
	assign wa = clearing ? clr_q[AW-1:0] : AW'(item_q.channel);
	assign wd = clearing ? '0 : {c1_next, n1_next};

	slc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quo(div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:  if (clr_q == CW'(CHANNELS - 1)) state_d = S_IDLE;
			S_IDLE: if (!q_empty) state_d = S_EXX;
			S_EXX:  state_d = S_EXA;
			S_EXA:  state_d = S_EXB;
			S_EXB:  state_d = S_EXT;
			S_EXT:  state_d = S_EXK;
			S_EXK:  state_d = S_EXM;
			S_EXM:  state_d = S_EXP;
			S_EXP:  state_d = (pstep_q == PSTEP_LAST) ? S_EXS : S_EXM;
			S_EXS:  state_d = S_GATE;
			S_GATE: state_d = (op_q == OP_I) ? S_EXX : S_DIVW;
			S_DIVW: if (div_done) state_d = (op_q == OP_O) ? S_U1 : S_EXX;
			S_U1:   state_d = S_U2;
			S_U2:   state_d = S_U3;
			S_U3:   state_d = S_U4;
			S_U4:   state_d = S_U5;
			S_U5:   state_d = S_QW;
			S_QW:   if (div_done) state_d = S_H1;
			S_H1:   state_d = S_H2;
			S_H2:   state_d = S_OUT;
			S_OUT:  if (!res_full) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			op_q    <= OP_F;
			pstep_q <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_IDLE) begin
				op_q <= OP_F;
			end else if ((state_q == S_GATE) && (op_q == OP_I)) begin
				op_q <= op_q + 1'b1;
			end else if ((state_q == S_DIVW) && div_done && (op_q != OP_O)) begin
				op_q <= op_q + 1'b1;
			end
			if (state_q == S_EXK) begin
				pstep_q <= '0;
			end else if (state_q == S_EXP) begin
				pstep_q <= pstep_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (q_pop) begin
			item_q <= q_head;
		end
		unique case (state_q)
			S_EXX: x_q <= x_cl[23:0];
			S_EXB: acc_q <= 60'(prod_q) <<< 15;
			S_EXT: t_q <= 26'(rs30(64'(acc_q) + 64'(prod_q)));
			S_EXK: begin
				k_q <= 9'(tk >>> 16);
				r_q <= signed'({1'b0, tk[15:0]}) - 17'sd32768;
				p_q <= POLY_C3;
			end
			S_EXP: p_q <= 19'(rs16(64'(prod_q))) + pc;
			S_EXS: e_q <= e_next;
			S_GATE: if (op_q == OP_I) ii_q <= e_q[31:0];
			S_DIVW: begin
				if (div_done) begin
					if (op_q == OP_F) fg_q <= g;
					if (op_q == OP_Z) zz_q <= signed'({g, 1'b0}) - 18'sd65536;
					if (op_q == OP_O) og_q <= g;
				end
			end
			S_U2: cf_q <= 42'(rs16(64'(prod_q)));
			S_U3: nacc_q <= 42'(rs16(64'(prod_q))) + signed'(42'(ii_q));
			S_U4: begin
				c1_q <= c1_next;
				n1_q <= n1_next;
			end
			S_QW: if (div_done) qv_q <= c1_q[ST_W-1] ? -signed'(qs) : signed'(qs);
			S_H2: begin
				if (h_full > 64'sd65536) begin
					h_q <= 18'sd65536;
				end else if (h_full < -64'sd65536) begin
					h_q <= -18'sd65536;
				end else begin
					h_q <= h_full[HID_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_q <= mem[ra];
		end
	end
endmodule

// ----- rtl/slstm_cell_step.sv -----
`timescale 1ns / 1ps
// One item at a time runs through a shared multiplier and a one-bit-per-cycle divider
// (four divides per item); the back end takes a new item only after its last result is out.
// Up to two items queue in front and two results queue at the output.
// Reset: arst_n clears control at once; then the state memory is cleared entry by entry,
// with full held high.
module slstm_cell_step
	import slc_pkg::*;
#(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [CH_W-1:0]          channel,
	input  logic signed [GATE_W-1:0] input_gate_raw,
	input  logic signed [GATE_W-1:0] forget_gate_raw,
	input  logic signed [GATE_W-1:0] cell_input_raw,
	input  logic signed [GATE_W-1:0] output_gate_raw,
	input  logic                     last_step,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [HID_W-1:0]  hidden_out,
	output logic [CH_W-1:0]          channel_out,
	output logic                     last_step_out
);
	logic      clearing, q_pop, q_empty, res_push, res_full;
	slc_item_t q_head;
	slc_res_t  res, res_head;

	slc_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.channel(channel),
		.input_gate_raw(input_gate_raw),
		.forget_gate_raw(forget_gate_raw),
		.cell_input_raw(cell_input_raw),
		.output_gate_raw(output_gate_raw),
		.last_step(last_step),
		.clearing(clearing),
		.q_pop(q_pop),
		.q_head(q_head),
		.q_empty(q_empty)
	);

	slc_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.clearing(clearing),
		.res_push(res_push),
		.res(res),
		.res_full(res_full)
	);

	slc_fifo #(
		.T(slc_res_t),
		.DEPTH(FIFO_DEPTH)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res),
		.full(res_full),
		.pop(pop),
		.rdata(res_head),
		.empty(empty)
	);

	assign hidden_out    = res_head.hidden;
	assign channel_out   = res_head.channel;
	assign last_step_out = res_head.last;
endmodule

// ----- rtl/slc_checker.sv -----
`timescale 1ns / 1ps
module slc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic [9:0]         channel,
	input logic signed [23:0] input_gate_raw,
	input logic signed [23:0] forget_gate_raw,
	input logic signed [23:0] cell_input_raw,
	input logic signed [23:0] output_gate_raw,
	input logic               last_step,
	input logic               empty,
	input logic               pop,
	input logic signed [17:0] hidden_out,
	input logic [9:0]         channel_out,
	input logic               last_step_out
);
	logic [3:0] pend_q;
	logic in_acc, out_acc;

	assign in_acc  = push & ~full;
	assign out_acc = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 4'd0)
		else $error("result shown with no transaction outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd5)
		else $error("more transactions outstanding than storage");

	a_hidden_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (hidden_out >= -18'sd65536 && hidden_out <= 18'sd65536))
		else $error("hidden_out out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(hidden_out) && $stable(channel_out)
			&& $stable(last_step_out))
		else $error("stalled result changed");
endmodule

bind slstm_cell_step slc_checker u_chk (.*);
